// File: hw/rtl/muas_pkg.sv
// Shared widths, constants and saturation helper for the mask UV plane setup block.
package muas_pkg;

    localparam int C_W         = 32;   // word width of every fixed-point value
    localparam int C_FRAC_BITS = 16;   // default fraction bits
    localparam int C_QB        = 32;   // quotient bits produced by the dividers
    localparam int C_D_W       = 33;   // difference of two words
    localparam int C_P_W       = 66;   // difference of two products of differences
    localparam int C_NC_W      = 100;  // constant-term numerator
    localparam int C_SPLIT     = 34;   // low part width when a wide factor is split
    localparam int C_IN_W      = 736;
    localparam int C_OUT_W     = 192;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = x[31:0];
        end
    endfunction

endpackage

// File: hw/rtl/muas_div.sv
// Pipelined restoring divider: rounded magnitude quotient, clamped, one bit per stage.
module muas_div #(
    parameter int NW = 64,
    parameter int DW = 33,
    parameter int QB = muas_pkg::C_QB
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [NW-1:0]        i_num,
    input  logic [DW-1:0]        i_den,
    input  logic                 i_neg,
    output logic signed [QB:0]   o_quot
);

    localparam int SW = ((NW > DW) ? NW : DW) + 1;
    localparam int RW = DW + QB;
    localparam int CW = (SW > RW) ? SW : RW;

    logic [SW-1:0] n_sum;
    logic          n_ovf;
    logic [RW-1:0] n_rem0;
    logic [RW:0]   n_diff [1:QB];
    logic [RW-1:0] n_rem  [1:QB-1];
    logic [QB-1:0] n_q    [1:QB];

    logic [RW-1:0] r_rem [0:QB-1];
    logic [DW-1:0] r_den [0:QB-1];
    logic [QB-1:0] r_q   [1:QB];
    logic [QB:0]   r_neg;
    logic [QB:0]   r_ovf;
    logic [QB-1:0] mag;

    always_comb begin
        // add half the divisor for round-to-nearest, ties away from zero
        n_sum  = SW'(i_num) + SW'(i_den >> 1);
        n_ovf  = CW'(n_sum) >= CW'({i_den, {QB{1'b0}}});
        n_rem0 = RW'(n_sum);
        for (int k = 1; k <= QB; k++) begin
            n_diff[k] = {1'b0, r_rem[k-1]} - ((RW+1)'(r_den[k-1]) << (QB - k));
            n_q[k]    = (k == 1) ? '0 : r_q[k-1];
            if (!n_diff[k][RW]) begin
                n_q[k][QB-k] = 1'b1;
            end
            if (k < QB) begin
                n_rem[k] = n_diff[k][RW] ? r_rem[k-1] : n_diff[k][RW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem0;
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
            r_ovf[0] <= n_ovf;
            for (int k = 1; k <= QB; k++) begin
                r_q[k]   <= n_q[k];
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
                if (k < QB) begin
                    r_rem[k] <= n_rem[k];
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign mag    = r_ovf[QB] ? '1 : r_q[QB];
    assign o_quot = r_neg[QB] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

// File: hw/rtl/mask_uv_affine_setup_top.sv
// Mask UV affine plane setup: atlas adjust, mask interpolation, Cramer solve, saturation.
// Pipeline depth: 2*32+12 = 76 stages; two banks of 32-stage restoring dividers set most of it.
// Throughput: one request per cycle while the output is not stalled.
// Backpressure holds the whole pipeline; the first stage still fills while it is empty.
// Reset (i_rst_n, synchronous, active low) clears the stage valid bits only.
module mask_uv_affine_setup_top #(
    parameter int FRAC_BITS = muas_pkg::C_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // corner0_uv, corner1_uv, corner2_uv, corner0_xy, corner1_xy, corner2_xy,
    // atlas_scale, atlas_offset, mask_top_left, mask_bottom_right,
    // mask_uv_start, mask_uv_end
    input  logic [muas_pkg::C_IN_W-1:0]   i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // u_gain_u, u_gain_v, u_bias, v_gain_u, v_gain_v, v_bias
    output logic [muas_pkg::C_OUT_W-1:0]  o_m_axis_tdata,
    // ok
    output logic                          o_m_axis_tuser
);

    localparam int QB  = muas_pkg::C_QB;
    localparam int NST = 2*QB + 12;
    localparam int PW  = muas_pkg::C_P_W;
    localparam int NCW = muas_pkg::C_NC_W;
    localparam int LW  = muas_pkg::C_SPLIT;
    localparam int NW1 = 2*muas_pkg::C_W;
    localparam int NAW = PW + FRAC_BITS;
    localparam int NW2 = (NAW > NCW) ? NAW : NCW;

    typedef struct packed {
        logic signed [32:0]   du1;
        logic signed [32:0]   du2;
        logic signed [32:0]   dv1;
        logic signed [32:0]   dv2;
        logic signed [31:0]   u0;
        logic signed [31:0]   v0;
        logic signed [31:0]   mu0;
        logic signed [31:0]   mv0;
        logic signed [PW-1:0] pd1;
        logic signed [PW-1:0] pd2;
        logic                 zwh;
    } t_side1;

    logic [NST:1] r_vld;
    logic         en;
    logic         ld0;

    // unpacked input fields
    logic signed [31:0] w_u [0:2];
    logic signed [31:0] w_v [0:2];
    logic signed [31:0] w_x [0:2];
    logic signed [31:0] w_y [0:2];
    logic signed [31:0] w_scale, w_offu, w_offv, w_tlx, w_tly, w_brx, w_bry;
    logic signed [31:0] w_msu, w_msv, w_meu, w_mev;

    // stage 1
    logic signed [63:0] r1_pu [0:2];
    logic signed [63:0] r1_pv [0:2];
    logic signed [32:0] r1_dx [0:2];
    logic signed [32:0] r1_dy [0:2];
    logic signed [31:0] r1_offu, r1_offv, r1_mu0, r1_mv0;
    logic signed [32:0] r1_mdu, r1_mdv, r1_mw, r1_mh;

    // stage 2
    logic signed [31:0]   r2_u  [0:2];
    logic signed [31:0]   r2_v  [0:2];
    logic signed [PW-1:0] r2_px [0:2];
    logic signed [PW-1:0] r2_py [0:2];
    logic signed [31:0]   r2_mu0, r2_mv0;
    logic signed [32:0]   r2_mw, r2_mh;
    logic                 r2_zwh;

    // stage 3 side data and first divider
    t_side1             n_s1;
    t_side1             r_s1 [0:QB];
    logic [NW1-1:0]     w_n1 [0:5];
    logic [32:0]        w_d1 [0:5];
    logic               w_g1 [0:5];
    logic signed [QB:0] w_q1 [0:5];

    // plane stages
    logic signed [31:0]   r36_tu [0:2];
    logic signed [31:0]   r36_tv [0:2];
    logic signed [PW-1:0] r36_det;
    logic signed [32:0]   r36_du1, r36_du2, r36_dv1, r36_dv2;
    logic signed [31:0]   r36_u0, r36_v0;
    logic                 r36_zwh;

    logic signed [32:0]   w_dt1 [0:1];
    logic signed [32:0]   w_dt2 [0:1];
    logic signed [PW-1:0] r37_m  [0:1][0:3];
    logic signed [PW-1:0] r37_det;
    logic signed [31:0]   r37_t0 [0:1];
    logic signed [31:0]   r37_u0, r37_v0;
    logic                 r37_zwh, r37_detz;

    logic signed [PW-1:0] r38_na [0:1];
    logic signed [PW-1:0] r38_nb [0:1];
    logic signed [PW-1:0] r38_det;
    logic signed [31:0]   r38_t0 [0:1];
    logic signed [31:0]   r38_u0, r38_v0;
    logic                 r38_zwh, r38_detz;

    logic signed [PW-1:0] w_x39 [0:1][0:2];
    logic signed [31:0]   w_y39 [0:1][0:2];
    logic signed [LW+32:0] r39_pl [0:1][0:2];
    logic signed [63:0]   r39_ph [0:1][0:2];
    logic signed [PW-1:0] r39_na [0:1];
    logic signed [PW-1:0] r39_nb [0:1];
    logic signed [PW-1:0] r39_det;
    logic                 r39_zwh, r39_detz;

    logic signed [NCW-1:0] r40_t [0:1][0:2];
    logic signed [PW-1:0]  r40_na [0:1];
    logic signed [PW-1:0]  r40_nb [0:1];
    logic signed [PW-1:0]  r40_det;
    logic                  r40_zwh, r40_detz;

    logic signed [NCW-1:0] r41_nc [0:1];
    logic signed [PW-1:0]  r41_na [0:1];
    logic signed [PW-1:0]  r41_nb [0:1];
    logic signed [PW-1:0]  r41_det;
    logic                  r41_zwh, r41_detz;

    logic signed [NAW-1:0] w_sa [0:1];
    logic signed [NAW-1:0] w_sb [0:1];
    logic [NAW-1:0]        w_ma [0:1];
    logic [NAW-1:0]        w_mb [0:1];
    logic [NCW-1:0]        w_mc [0:1];
    logic [NW2-1:0]        r42_num [0:5];
    logic                  r42_neg [0:5];
    logic [PW-1:0]         r42_den;
    logic                  r42_zwh, r42_detz;

    logic [1:0]            r_s2 [0:QB];
    logic signed [QB:0]    w_q2 [0:5];

    logic                  r_ok;
    logic signed [31:0]    r_coef [0:5];

    function automatic logic signed [63:0] rnd_frac(input logic signed [63:0] p);
        logic [63:0] m;
        logic [63:0] q;
        m = p[63] ? 64'(-p) : 64'(p);
        q = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        rnd_frac = p[63] ? -$signed(q) : $signed(q);
    endfunction

    // ---------------- handshake and valid line ----------------
    assign en              = !r_vld[NST] || i_m_axis_tready;
    assign ld0             = en || !r_vld[1];
    assign o_s_axis_tready = ld0;
    assign o_m_axis_tvalid = r_vld[NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (ld0) begin
                r_vld[1] <= i_s_axis_tvalid;
            end
            if (en) begin
                for (int k = 2; k <= NST; k++) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: atlas products, mask differences ----------------
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_u[i] = i_s_axis_tdata[64*i+32 +: 32];
            w_v[i] = i_s_axis_tdata[64*i    +: 32];
            w_x[i] = i_s_axis_tdata[192+64*i+32 +: 32];
            w_y[i] = i_s_axis_tdata[192+64*i    +: 32];
        end
        w_scale = i_s_axis_tdata[415:384];
        w_offu  = i_s_axis_tdata[479:448];
        w_offv  = i_s_axis_tdata[447:416];
        w_tlx   = i_s_axis_tdata[543:512];
        w_tly   = i_s_axis_tdata[511:480];
        w_brx   = i_s_axis_tdata[607:576];
        w_bry   = i_s_axis_tdata[575:544];
        w_msu   = i_s_axis_tdata[671:640];
        w_msv   = i_s_axis_tdata[639:608];
        w_meu   = i_s_axis_tdata[735:704];
        w_mev   = i_s_axis_tdata[703:672];
    end

    always_ff @(posedge i_clk) begin
        if (ld0) begin
            for (int i = 0; i < 3; i++) begin
                r1_pu[i] <= w_scale * w_u[i];
                r1_pv[i] <= w_scale * w_v[i];
                r1_dx[i] <= 33'(w_x[i]) - 33'(w_tlx);
                r1_dy[i] <= 33'(w_y[i]) - 33'(w_tly);
            end
            r1_offu <= w_offu;
            r1_offv <= w_offv;
            r1_mu0  <= w_msu;
            r1_mv0  <= w_msv;
            r1_mdu  <= 33'(w_meu) - 33'(w_msu);
            r1_mdv  <= 33'(w_mev) - 33'(w_msv);
            r1_mw   <= 33'(w_brx) - 33'(w_tlx);
            r1_mh   <= 33'(w_bry) - 33'(w_tly);
        end
    end

    // ---------------- stage 2: adjusted UVs, interpolation products ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r2_u[i]  <= muas_pkg::sat32(rnd_frac(r1_pu[i]) + 64'(r1_offu));
                r2_v[i]  <= muas_pkg::sat32(rnd_frac(r1_pv[i]) + 64'(r1_offv));
                r2_px[i] <= r1_dx[i] * r1_mdu;
                r2_py[i] <= r1_dy[i] * r1_mdv;
            end
            r2_mu0 <= r1_mu0;
            r2_mv0 <= r1_mv0;
            r2_mw  <= r1_mw;
            r2_mh  <= r1_mh;
            r2_zwh <= (r1_mw == '0) || (r1_mh == '0);
        end
    end

    // ---------------- stage 3: edge deltas, determinant products, divider 1 ----------------
    always_comb begin
        n_s1.du1 = 33'(r2_u[1]) - 33'(r2_u[0]);
        n_s1.du2 = 33'(r2_u[2]) - 33'(r2_u[0]);
        n_s1.dv1 = 33'(r2_v[1]) - 33'(r2_v[0]);
        n_s1.dv2 = 33'(r2_v[2]) - 33'(r2_v[0]);
        n_s1.u0  = r2_u[0];
        n_s1.v0  = r2_v[0];
        n_s1.mu0 = r2_mu0;
        n_s1.mv0 = r2_mv0;
        n_s1.pd1 = n_s1.du1 * n_s1.dv2;
        n_s1.pd2 = n_s1.du2 * n_s1.dv1;
        n_s1.zwh = r2_zwh;
        for (int i = 0; i < 3; i++) begin
            w_n1[i]   = r2_px[i][PW-1] ? NW1'(-r2_px[i]) : NW1'(r2_px[i]);
            w_n1[3+i] = r2_py[i][PW-1] ? NW1'(-r2_py[i]) : NW1'(r2_py[i]);
            w_d1[i]   = r2_mw[32] ? 33'(-r2_mw) : 33'(r2_mw);
            w_d1[3+i] = r2_mh[32] ? 33'(-r2_mh) : 33'(r2_mh);
            w_g1[i]   = r2_px[i][PW-1] ^ r2_mw[32];
            w_g1[3+i] = r2_py[i][PW-1] ^ r2_mh[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1[0] <= n_s1;
            for (int k = 1; k <= QB; k++) begin
                r_s1[k] <= r_s1[k-1];
            end
        end
    end

    for (genvar l = 0; l < 6; l++) begin : g_div1
        muas_div #(
            .NW (NW1),
            .DW (33),
            .QB (QB)
        ) u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (w_n1[l]),
            .i_den  (w_d1[l]),
            .i_neg  (w_g1[l]),
            .o_quot (w_q1[l])
        );
    end

    // ---------------- mask UVs at the corners, determinant ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r36_tu[i] <= muas_pkg::sat32(64'(w_q1[i])   + 64'(r_s1[QB].mu0));
                r36_tv[i] <= muas_pkg::sat32(64'(w_q1[3+i]) + 64'(r_s1[QB].mv0));
            end
            r36_det <= r_s1[QB].pd1 - r_s1[QB].pd2;
            r36_du1 <= r_s1[QB].du1;
            r36_du2 <= r_s1[QB].du2;
            r36_dv1 <= r_s1[QB].dv1;
            r36_dv2 <= r_s1[QB].dv2;
            r36_u0  <= r_s1[QB].u0;
            r36_v0  <= r_s1[QB].v0;
            r36_zwh <= r_s1[QB].zwh;
        end
    end

    // ---------------- Cramer numerator products ----------------
    always_comb begin
        w_dt1[0] = 33'(r36_tu[1]) - 33'(r36_tu[0]);
        w_dt2[0] = 33'(r36_tu[2]) - 33'(r36_tu[0]);
        w_dt1[1] = 33'(r36_tv[1]) - 33'(r36_tv[0]);
        w_dt2[1] = 33'(r36_tv[2]) - 33'(r36_tv[0]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int p = 0; p < 2; p++) begin
                r37_m[p][0] <= w_dt1[p] * r36_dv2;
                r37_m[p][1] <= w_dt2[p] * r36_dv1;
                r37_m[p][2] <= r36_du1 * w_dt2[p];
                r37_m[p][3] <= r36_du2 * w_dt1[p];
            end
            r37_t0[0] <= r36_tu[0];
            r37_t0[1] <= r36_tv[0];
            r37_det   <= r36_det;
            r37_detz  <= (r36_det == '0);
            r37_u0    <= r36_u0;
            r37_v0    <= r36_v0;
            r37_zwh   <= r36_zwh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int p = 0; p < 2; p++) begin
                r38_na[p] <= r37_m[p][0] - r37_m[p][1];
                r38_nb[p] <= r37_m[p][2] - r37_m[p][3];
                r38_t0[p] <= r37_t0[p];
            end
            r38_det  <= r37_det;
            r38_u0   <= r37_u0;
            r38_v0   <= r37_v0;
            r38_zwh  <= r37_zwh;
            r38_detz <= r37_detz;
        end
    end

    // ---------------- constant term: split wide factors into partial products ----------------
    always_comb begin
        for (int p = 0; p < 2; p++) begin
            w_x39[p][0] = r38_det;
            w_y39[p][0] = r38_t0[p];
            w_x39[p][1] = r38_na[p];
            w_y39[p][1] = r38_u0;
            w_x39[p][2] = r38_nb[p];
            w_y39[p][2] = r38_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int p = 0; p < 2; p++) begin
                for (int j = 0; j < 3; j++) begin
                    r39_pl[p][j] <= $signed({1'b0, w_x39[p][j][LW-1:0]}) * w_y39[p][j];
                    r39_ph[p][j] <= $signed(w_x39[p][j][PW-1:LW]) * w_y39[p][j];
                end
                r39_na[p] <= r38_na[p];
                r39_nb[p] <= r38_nb[p];
            end
            r39_det  <= r38_det;
            r39_zwh  <= r38_zwh;
            r39_detz <= r38_detz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int p = 0; p < 2; p++) begin
                for (int j = 0; j < 3; j++) begin
                    r40_t[p][j] <= (NCW'(r39_ph[p][j]) <<< LW) + NCW'(r39_pl[p][j]);
                end
                r40_na[p] <= r39_na[p];
                r40_nb[p] <= r39_nb[p];
            end
            r40_det  <= r39_det;
            r40_zwh  <= r39_zwh;
            r40_detz <= r39_detz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int p = 0; p < 2; p++) begin
                r41_nc[p] <= r40_t[p][0] - r40_t[p][1] - r40_t[p][2];
                r41_na[p] <= r40_na[p];
                r41_nb[p] <= r40_nb[p];
            end
            r41_det  <= r40_det;
            r41_zwh  <= r40_zwh;
            r41_detz <= r40_detz;
        end
    end

    // ---------------- magnitudes and signs for divider 2 ----------------
    always_comb begin
        for (int p = 0; p < 2; p++) begin
            w_sa[p] = NAW'(r41_na[p]) <<< FRAC_BITS;
            w_sb[p] = NAW'(r41_nb[p]) <<< FRAC_BITS;
            w_ma[p] = w_sa[p][NAW-1] ? -w_sa[p] : w_sa[p];
            w_mb[p] = w_sb[p][NAW-1] ? -w_sb[p] : w_sb[p];
            w_mc[p] = r41_nc[p][NCW-1] ? -r41_nc[p] : r41_nc[p];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int p = 0; p < 2; p++) begin
                r42_num[3*p]   <= NW2'(w_ma[p]);
                r42_num[3*p+1] <= NW2'(w_mb[p]);
                r42_num[3*p+2] <= NW2'(w_mc[p]);
                r42_neg[3*p]   <= r41_na[p][PW-1] ^ r41_det[PW-1];
                r42_neg[3*p+1] <= r41_nb[p][PW-1] ^ r41_det[PW-1];
                r42_neg[3*p+2] <= r41_nc[p][NCW-1] ^ r41_det[PW-1];
            end
            r42_den  <= r41_det[PW-1] ? PW'(-r41_det) : PW'(r41_det);
            r42_zwh  <= r41_zwh;
            r42_detz <= r41_detz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2[0] <= {r42_zwh, r42_detz};
            for (int k = 1; k <= QB; k++) begin
                r_s2[k] <= r_s2[k-1];
            end
        end
    end

    for (genvar l = 0; l < 6; l++) begin : g_div2
        muas_div #(
            .NW (NW2),
            .DW (PW),
            .QB (QB)
        ) u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r42_num[l]),
            .i_den  (r42_den),
            .i_neg  (r42_neg[l]),
            .o_quot (w_q2[l])
        );
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ok <= !(r_s2[QB][1] || r_s2[QB][0]);
            for (int l = 0; l < 6; l++) begin
                // degenerate rectangle or collinear corners give all-zero coefficients
                r_coef[l] <= (r_s2[QB][1] || r_s2[QB][0]) ? '0
                                                          : muas_pkg::sat32(64'(w_q2[l]));
            end
        end
    end

    assign o_m_axis_tdata = {r_coef[5], r_coef[4], r_coef[3], r_coef[2], r_coef[1], r_coef[0]};
    assign o_m_axis_tuser = r_ok;

    // ---------------- assertions ----------------
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_vld[1] && r_vld[NST] && !i_m_axis_tready))
        else $error("input stalled without a full pipe and a blocked output");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("failed setup carries nonzero coefficients");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NST] && !i_m_axis_tready) |=> r_vld[NST])
        else $error("waiting result dropped");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[1])
        else $error("accepted request not captured in first stage");

endmodule

// File: bench/tb_mask_uv_affine_setup_top.sv
// Self-checking bench for the mask UV affine plane setup block.
`timescale 1ns / 100ps

module tb_mask_uv_affine_setup_top;

    localparam int FRAC     = muas_pkg::C_FRAC_BITS;
    localparam int LATENCY  = 76;
    localparam int WD_LIMIT = 4000;

    typedef logic signed [191:0] t_wide;

    typedef struct {
        logic [63:0]        uv [3];
        logic [63:0]        xy [3];
        logic signed [31:0] scale;
        logic [63:0]        offset;
        logic [63:0]        tl;
        logic [63:0]        br;
        logic [63:0]        muv0;
        logic [63:0]        muv1;
    } t_quad;

    typedef struct {
        logic               ok;
        logic signed [31:0] coef [6];
    } t_planes;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_s_axis_tvalid;
    logic                           o_s_axis_tready;
    logic [muas_pkg::C_IN_W-1:0]    i_s_axis_tdata;   // corner0_uv .. mask_uv_end, low bits first
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready;
    // u_gain_u, u_gain_v, u_bias, v_gain_u, v_gain_v, v_bias
    logic [muas_pkg::C_OUT_W-1:0]   o_m_axis_tdata;
    logic                           o_m_axis_tuser;   // ok

    t_planes planes_pending [$];
    int      n_err;
    int      n_sent;
    int      n_recv;
    int      n_ok;
    int      idle_cycles;
    int      stall_left;
    bit      quiet;
    bit      src_idle;

    mask_uv_affine_setup_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- prediction ----------------
    function automatic t_wide hi_w(logic [63:0] w);
        t_wide r;
        r = 192'($signed(w[63:32]));
        return r;
    endfunction

    function automatic t_wide lo_w(logic [63:0] w);
        t_wide r;
        r = 192'($signed(w[31:0]));
        return r;
    endfunction

    // round to nearest, ties away from zero; zero divisor gives zero
    function automatic t_wide div_round(t_wide n, t_wide d);
        t_wide nm;
        t_wide dm;
        t_wide q;
        if (d == 0) return '0;
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        q = (nm + (dm >>> 1)) / dm;
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic t_wide clamp32(t_wide x);
        if (x > 192'sd2147483647) return 192'sd2147483647;
        if (x < -192'sd2147483648) return -192'sd2147483648;
        return x;
    endfunction

    function automatic void solve_plane(input t_wide u [3], input t_wide v [3],
                                        input t_wide t [3], input t_wide det,
                                        output logic signed [31:0] g_u,
                                        output logic signed [31:0] g_v,
                                        output logic signed [31:0] bias);
        t_wide na;
        t_wide nb;
        t_wide nc;
        na = (t[1] - t[0]) * (v[2] - v[0]) - (t[2] - t[0]) * (v[1] - v[0]);
        nb = (u[1] - u[0]) * (t[2] - t[0]) - (u[2] - u[0]) * (t[1] - t[0]);
        nc = det * t[0] - na * u[0] - nb * v[0];
        g_u  = 32'(clamp32(div_round(na <<< FRAC, det)));
        g_v  = 32'(clamp32(div_round(nb <<< FRAC, det)));
        bias = 32'(clamp32(div_round(nc, det)));
    endfunction

    function automatic t_planes predict_planes(t_quad q);
        t_planes r;
        t_wide   u [3];
        t_wide   v [3];
        t_wide   tu [3];
        t_wide   tv [3];
        t_wide   one;
        t_wide   sc;
        t_wide   mw;
        t_wide   mh;
        t_wide   mdu;
        t_wide   mdv;
        t_wide   det;
        r.ok = 1'b0;
        foreach (r.coef[k]) r.coef[k] = '0;
        one = 192'sd1 <<< FRAC;
        sc  = 192'(q.scale);
        mw  = hi_w(q.br) - hi_w(q.tl);
        mh  = lo_w(q.br) - lo_w(q.tl);
        mdu = hi_w(q.muv1) - hi_w(q.muv0);
        mdv = lo_w(q.muv1) - lo_w(q.muv0);
        if (mw == 0 || mh == 0) return r;
        for (int k = 0; k < 3; k++) begin
            u[k]  = clamp32(div_round(sc * hi_w(q.uv[k]), one) + hi_w(q.offset));
            v[k]  = clamp32(div_round(sc * lo_w(q.uv[k]), one) + lo_w(q.offset));
            tu[k] = clamp32(div_round((hi_w(q.xy[k]) - hi_w(q.tl)) * mdu, mw)
                            + hi_w(q.muv0));
            tv[k] = clamp32(div_round((lo_w(q.xy[k]) - lo_w(q.tl)) * mdv, mh)
                            + lo_w(q.muv0));
        end
        det = (u[1] - u[0]) * (v[2] - v[0]) - (u[2] - u[0]) * (v[1] - v[0]);
        if (det == 0) return r;
        solve_plane(u, v, tu, det, r.coef[0], r.coef[1], r.coef[2]);
        solve_plane(u, v, tv, det, r.coef[3], r.coef[4], r.coef[5]);
        r.ok = 1'b1;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic logic [63:0] pair(int a, int b);
        return {a[31:0], b[31:0]};
    endfunction

    function automatic int srand(int bits);
        return int'($urandom_range(0, (2 ** (bits + 1)) - 1)) - (2 ** bits);
    endfunction

    function automatic t_quad noise_quad();
        t_quad q;
        for (int k = 0; k < 3; k++) begin
            q.uv[k] = {$urandom, $urandom};
            q.xy[k] = {$urandom, $urandom};
        end
        q.scale  = $urandom;
        q.offset = {$urandom, $urandom};
        q.tl     = {$urandom, $urandom};
        q.br     = {$urandom, $urandom};
        q.muv0   = {$urandom, $urandom};
        q.muv1   = {$urandom, $urandom};
        return q;
    endfunction

    // plausible quad: modest texcoords, scale of 1.0 or random in [-8.0, 8.0), random mask rectangle
    function automatic t_quad sane_quad();
        t_quad q;
        int    x0;
        int    y0;
        for (int k = 0; k < 3; k++) begin
            q.uv[k] = pair(srand(18), srand(18));
            q.xy[k] = pair(srand(26), srand(26));
        end
        q.scale  = ($urandom_range(0, 3) == 0) ? 32'sh0001_0000 : srand(19);
        q.offset = ($urandom_range(0, 2) == 0) ? 64'd0 : pair(srand(20), srand(20));
        x0 = srand(26);
        y0 = srand(26);
        q.tl   = pair(x0, y0);
        q.br   = pair(x0 + srand(24), y0 + srand(24));
        q.muv0 = pair(srand(17), srand(17));
        q.muv1 = pair(srand(17), srand(17));
        return q;
    endfunction

    function automatic logic [muas_pkg::C_IN_W-1:0] pack_quad(t_quad q);
        return {q.muv1, q.muv0, q.br, q.tl, q.offset, q.scale,
                q.xy[2], q.xy[1], q.xy[0], q.uv[2], q.uv[1], q.uv[0]};
    endfunction

    task automatic send_quad(t_quad q);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pack_quad(q);
        do @(posedge i_clk); while (!o_s_axis_tready);
        planes_pending = {planes_pending, predict_planes(q)};
        n_sent++;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
        end else if (src_idle) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        wait (planes_pending.size() == 0);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic report(string what, int idx, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch result %0d %s: got %h want %h", $realtime, idx, what,
                 got, want);
        n_err++;
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        t_quad b;
        t_quad q;
        src_idle = 1'b1;
        b.uv[0] = pair(0, 0);
        b.uv[1] = pair(32'sh0001_0000, 0);
        b.uv[2] = pair(0, 32'sh0001_0000);
        b.xy[0] = pair(32'sh0010_0000, 32'sh0010_0000);
        b.xy[1] = pair(32'sh0050_0000, 32'sh0010_0000);
        b.xy[2] = pair(32'sh0010_0000, 32'sh0030_0000);
        b.scale = 32'sh0001_0000;
        b.offset = '0;
        b.tl   = pair(0, 0);
        b.br   = pair(32'sh0140_0000, 32'sh00E0_0000);
        b.muv0 = pair(0, 0);
        b.muv1 = pair(32'sh0001_0000, 32'sh0001_0000);
        send_quad(b);
        q = b; q.br = pair(0, 32'sh00E0_0000); send_quad(q);          // zero-width mask
        q = b; q.br = pair(32'sh0140_0000, 0); send_quad(q);          // zero-height mask
        q = b; q.uv[2] = pair(32'sh0002_0000, 0); send_quad(q);       // collinear corners
        q = b; q.scale = 0; send_quad(q);                             // scale zero: det zero
        q = b; q.scale = 32'sh8000_0000; send_quad(q);
        q = b; q.scale = 32'sh7FFF_FFFF; send_quad(q);
        q = b; q.offset = pair(32'sh7FFF_FFFF, 32'sh8000_0000); send_quad(q);
        q = b; q.muv1 = pair(32'sh7FFF_FFFF, 32'sh8000_0000); send_quad(q);
        q = b; q.tl = pair(32'sh8000_0000, 32'sh8000_0000);
        q.br = pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF); send_quad(q);
        q = b; q.uv[1] = pair(32'sh0000_0001, 0); q.uv[2] = pair(0, 32'sh0000_0001);
        send_quad(q);                                                 // tiny det: saturating gains
        q = b; q.uv[0] = pair(32'sh8000_0000, 32'sh8000_0000);
        q.uv[1] = pair(32'sh7FFF_FFFF, 32'sh8000_0000);
        q.uv[2] = pair(32'sh8000_0000, 32'sh7FFF_FFFF); send_quad(q);
        q = b; q.xy[0] = pair(32'sh8000_0000, 32'sh7FFF_FFFF);
        q.xy[1] = pair(32'sh7FFF_FFFF, 32'sh8000_0000); send_quad(q);
        q = b; q.scale = 32'shFFFF_0000; q.muv0 = pair(-1, -1); send_quad(q);
        q = b; q.scale = 32'sh0000_8000; q.uv[1] = pair(1, 3); send_quad(q); // rounding ties
        q = b; q.uv[0] = {64{1'b1}}; q.xy[2] = {64{1'b1}}; send_quad(q);
        src_idle = 1'b0;
    endtask

    task automatic test_random_quads(int count);
        t_quad q;
        for (int n = 0; n < count; n++) begin
            q = sane_quad();
            case ($urandom_range(0, 19))
                0: q.br = pair(q.tl[63:32], q.br[31:0]);
                1: q.br = pair(q.br[63:32], q.tl[31:0]);
                2: q.uv[2] = q.uv[1];
                default: ;
            endcase
            send_quad(q);
        end
    endtask

    task automatic test_random_noise(int count);
        for (int n = 0; n < count; n++) send_quad(noise_quad());
    endtask

    // ---------------- result side ----------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left      <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            stall_left      <= $urandom_range(1, 19) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_planes want;
        logic [31:0] got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (planes_pending.size() == 0) begin
                $display("[%0t] result with nothing outstanding", $realtime);
                n_err++;
            end else begin
                want = planes_pending.pop_front();
                if (o_m_axis_tuser !== want.ok)
                    report("ok", n_recv, {31'd0, o_m_axis_tuser}, {31'd0, want.ok});
                for (int k = 0; k < 6; k++) begin
                    got = o_m_axis_tdata[32*k +: 32];
                    if (got !== want.coef[k]) report($sformatf("coef%0d", k), n_recv, got,
                                                    want.coef[k]);
                end
                n_ok += want.ok;
            end
            n_recv++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WD_LIMIT) begin
            $display("tb_mask_uv_affine_setup_top: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        n_err = 0; n_sent = 0; n_recv = 0; n_ok = 0;
        idle_cycles = 0; stall_left = 0; quiet = 1'b0; src_idle = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_quads(700);
        hold_until_drained();
        test_random_noise(300);
        test_random_quads(500);
        quiet = 1'b1;
        test_random_quads(250);
        test_random_noise(50);

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        wait (planes_pending.size() == 0);
        repeat (LATENCY + 8) @(posedge i_clk);
        $display("sent %0d quads, checked %0d plane sets (%0d solvable, rest degenerate)",
                 n_sent, n_recv, n_ok);
        $display("covered degenerate masks, collinear corners, saturation, stalls and drain");
        if (n_err == 0 && planes_pending.size() == 0) begin
            $display("tb_mask_uv_affine_setup_top: clean");
        end else begin
            $display("tb_mask_uv_affine_setup_top: errors");
        end
        $finish;
    end

endmodule
